// ----- src/lbgk_pkg.sv -----
// Shared types, constants and arithmetic helpers of the D2Q9 BGK cell collision block.
`timescale 1ns / 1ps
package lbgk_pkg;

  localparam int WORD_W      = 32;
  localparam int FRAC_W      = 28;
  localparam int DIRS        = 9;
  localparam int WIDE_W      = 64;
  localparam int MOM_W       = 35;
  localparam int DIV_NUM_W   = 63;
  localparam int DIV_DEN_W   = 34;
  localparam int DIV_Q_W     = 34;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int REG_IDX_W   = 3;
  localparam int OUT_FIELDS  = 12;

  localparam logic signed [WIDE_W-1:0] ONE_W  = WIDE_W'(1) <<< FRAC_W;
  localparam logic signed [WIDE_W-1:0] SAT_HI = (WIDE_W'(1) <<< (WORD_W - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);

  localparam logic signed [1:0] DIR_X [DIRS] = '{2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0,
                                                 2'sd1, -2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] DIR_Y [DIRS] = '{2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1,
                                                 2'sd1, -2'sd1, -2'sd1, 2'sd1};

  typedef enum logic [1:0] {
    KIND_FLUID   = 2'd0,
    KIND_SOLID   = 2'd1,
    KIND_OUTFLOW = 2'd2,
    KIND_INFLOW  = 2'd3
  } kind_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FULL_EQ     = 3'd0,
    REG_OUTFLOW_RHO = 3'd1,
    REG_INFLOW_RHO  = 3'd2,
    REG_W_REST      = 3'd3,
    REG_W_AXIS      = 3'd4,
    REG_W_DIAG      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        full_eq;
    logic [30:0] outflow_rho;
    logic [30:0] inflow_rho;
    logic [28:0] w_rest;
    logic [28:0] w_axis;
    logic [28:0] w_diag;
  } cfg_t;

  typedef struct packed {
    kind_t                        kind;
    logic [DIRS-1:0][WORD_W-1:0]  dists;
    logic [WORD_W-1:0]            rho;
    logic [MOM_W-1:0]             mx;
    logic [MOM_W-1:0]             my;
  } cell_t;

  function automatic logic [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic [WORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[WORD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] sx(input logic [WORD_W-1:0] v);
    return WIDE_W'(signed'(v));
  endfunction

endpackage

// ----- src/lbgk_div.sv -----
// Pipelined restoring divider of a magnitude by a magnitude, one quotient bit per stage.
`timescale 1ns / 1ps
module lbgk_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [lbgk_pkg::DIV_NUM_W-1:0] num,
  input  logic [lbgk_pkg::DIV_DEN_W-1:0] den,
  output logic [lbgk_pkg::DIV_Q_W-1:0]   quo
);
  import lbgk_pkg::*;

  logic [DIV_DEN_W-1:0] rem   [0:DIV_Q_W];
  logic [DIV_Q_W-1:0]   low   [0:DIV_Q_W];
  logic [DIV_Q_W-1:0]   qb    [0:DIV_Q_W];
  logic [DIV_DEN_W-1:0] dd    [0:DIV_Q_W];
  logic                 ovf   [0:DIV_Q_W];
  logic [DIV_DEN_W:0]   trial [1:DIV_Q_W];
  logic [DIV_DEN_W:0]   sub   [1:DIV_Q_W];
  logic                 ge    [1:DIV_Q_W];
  logic [DIV_DEN_W-1:0] hi;

  assign hi = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);

  always_comb begin
    for (int k = 1; k <= DIV_Q_W; k++) begin
      trial[k] = {rem[k-1], low[k-1][DIV_Q_W-1]};
      sub[k]   = trial[k] - {1'b0, dd[k-1]};
      ge[k]    = trial[k] >= {1'b0, dd[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= hi;
      low[0] <= num[DIV_Q_W-1:0];
      qb[0]  <= '0;
      dd[0]  <= den;
      ovf[0] <= hi >= den;
      for (int k = 1; k <= DIV_Q_W; k++) begin
        rem[k] <= ge[k] ? sub[k][DIV_DEN_W-1:0] : trial[k][DIV_DEN_W-1:0];
        low[k] <= {low[k-1][DIV_Q_W-2:0], 1'b0};
        qb[k]  <= {qb[k-1][DIV_Q_W-2:0], ge[k]};
        dd[k]  <= dd[k-1];
        ovf[k] <= ovf[k-1];
      end
    end
  end

  assign quo = ovf[DIV_Q_W] ? '1 : qb[DIV_Q_W];

endmodule

// ----- src/lbgk_front.sv -----
// Front stage: takes a cell, sums density and momenta, pins density by cell kind.
`timescale 1ns / 1ps
module lbgk_front (
  input  logic                 clk,
  input  logic                 rst,
  input  lbgk_pkg::cfg_t       cfg,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [287:0]         s_tdata,  // dist_0 .. dist_8, 32 bits each
  input  logic [1:0]           s_tuser,  // cell_kind
  output logic                 push,
  output lbgk_pkg::cell_t      push_item,
  input  logic                 full
);
  import lbgk_pkg::*;

  logic                      front_valid;
  cell_t                     item;
  cell_t                     item_next;
  logic signed [WIDE_W-1:0]  fw [DIRS];
  logic signed [WIDE_W-1:0]  sum;
  logic signed [WIDE_W-1:0]  mx;
  logic signed [WIDE_W-1:0]  my;

  always_comb begin
    for (int q = 0; q < DIRS; q++) begin
      fw[q] = sx(s_tdata[q*WORD_W +: WORD_W]);
    end
    sum = ((fw[0] + fw[1]) + (fw[2] + fw[3])) + ((fw[4] + fw[5]) + (fw[6] + fw[7])) + fw[8];
    mx  = (fw[1] - fw[2]) + (fw[5] - fw[6]) + (fw[7] - fw[8]);
    my  = (fw[3] - fw[4]) + (fw[5] - fw[6]) + (fw[8] - fw[7]);
    item_next.kind = kind_t'(s_tuser);
    for (int q = 0; q < DIRS; q++) begin
      item_next.dists[q] = s_tdata[q*WORD_W +: WORD_W];
    end
    unique case (kind_t'(s_tuser))
      KIND_OUTFLOW: item_next.rho = {1'b0, cfg.outflow_rho};
      KIND_INFLOW:  item_next.rho = {1'b0, cfg.inflow_rho};
      default:      item_next.rho = sat_word(sum);
    endcase
    item_next.mx = mx[MOM_W-1:0];
    item_next.my = my[MOM_W-1:0];
  end

  assign s_tready  = !front_valid || !full;
  assign push      = front_valid && !full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_next;
    end
  end

endmodule

// ----- src/lbgk_queue.sv -----
// Short queue of classified cells between the front stage and the collision pipeline.
`timescale 1ns / 1ps
module lbgk_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lbgk_pkg::cell_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lbgk_pkg::cell_t head_item
);
  import lbgk_pkg::*;

  cell_t             mem [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + QCNT_W'(1)) else $error("count did not rise");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - QCNT_W'(1)) else $error("count did not fall");

endmodule

// ----- src/lbgk_back.sv -----
// Collision pipeline: velocity division, equilibrium, relaxation division and output register.
`timescale 1ns / 1ps
module lbgk_back (
  input  logic            clk,
  input  logic            rst,
  input  lbgk_pkg::cfg_t  cfg,
  input  logic            head_valid,
  input  lbgk_pkg::cell_t head_item,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [383:0]    m_tdata
);
  import lbgk_pkg::*;

  typedef struct packed {
    kind_t                       kind;
    logic [DIRS-1:0][WORD_W-1:0] dists;
    logic [WORD_W-1:0]           rho;
    logic [WORD_W-1:0]           ux;
    logic [WORD_W-1:0]           uy;
    logic [DIV_DEN_W-1:0]        tau;
    logic [2:0][WORD_W-1:0]      wr;
    logic                        neg_x;
    logic                        neg_y;
    logic                        rho_zero;
    logic [DIRS-1:0]             neg_d;
  } carry_t;

  logic adv;

  carry_t s1 [0:DIV_Q_W];
  logic   v1 [0:DIV_Q_W];
  carry_t s2 [0:DIV_Q_W];
  logic   v2 [0:DIV_Q_W];
  carry_t cv, ce1, ce2, ce3, ce4;
  logic   vv, ve1, ve2, ve3, ve4;
  carry_t s1_in, cv_in, s2_in;

  logic signed [WIDE_W-1:0]     rr;
  logic [2:0][WIDE_W-1:0]       wrp;
  logic [DIRS-1:0][WORD_W-1:0]  cu;
  logic [DIRS-1:0][WIDE_W-1:0]  cup;
  logic signed [WIDE_W-1:0]     uxx;
  logic signed [WIDE_W-1:0]     uyy;
  logic [DIRS-1:0][WORD_W-1:0]  polys;
  logic [DIRS-1:0][WIDE_W-1:0]  feqp;
  logic                         out_valid;
  logic [383:0]                 out_data;

  carry_t                       s0_in;
  logic signed [WIDE_W-1:0]     rho_w;
  logic signed [WIDE_W-1:0]     mx_w;
  logic signed [WIDE_W-1:0]     my_w;
  logic [WIDE_W-1:0]            mx_mag;
  logic [WIDE_W-1:0]            my_mag;
  logic [WIDE_W-1:0]            rho_mag;
  logic [DIV_NUM_W-1:0]         num_x;
  logic [DIV_NUM_W-1:0]         num_y;
  logic [DIV_DEN_W-1:0]         den_v;
  logic [DIV_Q_W-1:0]           qx;
  logic [DIV_Q_W-1:0]           qy;
  logic [DIV_DEN_W-1:0]         tau_c;
  logic [2:0][WORD_W-1:0]       wr_c;
  logic [WORD_W-1:0]            ux_c;
  logic [WORD_W-1:0]            uy_c;
  logic [DIRS-1:0][WORD_W-1:0]  cu_c;
  logic [DIRS-1:0][WORD_W-1:0]  poly_c;
  logic [DIRS-1:0][WORD_W-1:0]  feq_c;
  logic [DIRS-1:0][DIV_NUM_W-1:0] num_d;
  logic [DIRS-1:0]              neg_c;
  logic [DIRS-1:0][DIV_Q_W-1:0] qd;
  logic [383:0]                 out_c;

  logic signed [WIDE_W-1:0]     t_cu;
  logic signed [WIDE_W-1:0]     t_cu2;
  logic signed [WIDE_W-1:0]     t_usq;
  logic signed [WIDE_W-1:0]     t_poly;
  logic signed [WIDE_W-1:0]     t_diff;
  logic [WIDE_W-1:0]            t_mag;
  logic signed [WIDE_W-1:0]     t_q;
  logic signed [WIDE_W-1:0]     t_tau;
  logic signed [WIDE_W-1:0]     t_vx;
  logic signed [WIDE_W-1:0]     t_vy;

  assign adv      = !out_valid || m_tready;
  assign pop      = adv && head_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  function automatic int wclass(input int q);
    return (q == 0) ? 0 : ((q <= 4) ? 1 : 2);
  endfunction

  // Velocity divider operands and the carried cell.
  always_comb begin
    rho_w   = sx(head_item.rho);
    mx_w    = WIDE_W'(signed'(head_item.mx));
    my_w    = WIDE_W'(signed'(head_item.my));
    mx_mag  = mx_w[WIDE_W-1] ? -mx_w : mx_w;
    my_mag  = my_w[WIDE_W-1] ? -my_w : my_w;
    rho_mag = rho_w[WIDE_W-1] ? -rho_w : rho_w;
    num_x   = DIV_NUM_W'({mx_mag[MOM_W-2:0], {FRAC_W{1'b0}}});
    num_y   = DIV_NUM_W'({my_mag[MOM_W-2:0], {FRAC_W{1'b0}}});
    den_v   = rho_mag[DIV_DEN_W-1:0];
    s0_in          = '0;
    s0_in.kind     = head_item.kind;
    s0_in.dists    = head_item.dists;
    s0_in.rho      = head_item.rho;
    s0_in.neg_x    = head_item.mx[MOM_W-1] ^ head_item.rho[WORD_W-1];
    s0_in.neg_y    = head_item.my[MOM_W-1] ^ head_item.rho[WORD_W-1];
    s0_in.rho_zero = head_item.rho == '0;
  end

  lbgk_div u_div_x (.clk(clk), .en(adv), .num(num_x), .den(den_v), .quo(qx));
  lbgk_div u_div_y (.clk(clk), .en(adv), .num(num_y), .den(den_v), .quo(qy));

  // Relaxation time and weighted densities one stage after entry.
  always_comb begin
    t_tau = (ONE_W + (rr >>> FRAC_W)) >>> 1;
    tau_c = t_tau[DIV_DEN_W-1:0];
    for (int w = 0; w < 3; w++) begin
      wr_c[w] = sat_word(signed'(wrp[w]) >>> FRAC_W);
    end
    s1_in     = s1[0];
    s1_in.tau = tau_c;
    s1_in.wr  = wr_c;
  end

  // Velocity from the quotient magnitudes.
  always_comb begin
    t_vx = s1[DIV_Q_W].neg_x ? -signed'(WIDE_W'(qx)) : signed'(WIDE_W'(qx));
    t_vy = s1[DIV_Q_W].neg_y ? -signed'(WIDE_W'(qy)) : signed'(WIDE_W'(qy));
    ux_c = s1[DIV_Q_W].rho_zero ? '0 : sat_word(t_vx);
    uy_c = s1[DIV_Q_W].rho_zero ? '0 : sat_word(t_vy);
    cv_in    = s1[DIV_Q_W];
    cv_in.ux = ux_c;
    cv_in.uy = uy_c;
  end

  // Equilibrium polynomial pieces.
  always_comb begin
    t_cu  = '0;
    t_cu2 = '0;
    t_usq = (uxx >>> FRAC_W) + (uyy >>> FRAC_W);
    for (int q = 0; q < DIRS; q++) begin
      t_cu = WIDE_W'(DIR_X[q]) * sx(ce1.ux) + WIDE_W'(DIR_Y[q]) * sx(ce1.uy);
      cu_c[q] = sat_word(t_cu);
    end
    for (int q = 0; q < DIRS; q++) begin
      t_cu2  = signed'(cup[q]) >>> FRAC_W;
      t_poly = ONE_W + WIDE_W'(3) * sx(cu[q])
             + ((WIDE_W'(9) * t_cu2) >>> 1) - ((WIDE_W'(3) * t_usq) >>> 1);
      poly_c[q] = sat_word(t_poly);
    end
  end

  // Equilibrium and relaxation divider operands.
  always_comb begin
    t_diff = '0;
    t_mag  = '0;
    for (int q = 0; q < DIRS; q++) begin
      feq_c[q] = cfg.full_eq ? sat_word(signed'(feqp[q]) >>> FRAC_W) : ce4.wr[wclass(q)];
      t_diff   = sx(feq_c[q]) - sx(ce4.dists[q]);
      neg_c[q] = t_diff[WIDE_W-1];
      t_mag    = t_diff[WIDE_W-1] ? -t_diff : t_diff;
      num_d[q] = DIV_NUM_W'({t_mag[WORD_W:0], {FRAC_W{1'b0}}});
    end
    s2_in       = ce4;
    s2_in.neg_d = neg_c;
  end

  for (genvar g = 0; g < DIRS; g++) begin : g_relax
    lbgk_div u_div_r (.clk(clk), .en(adv), .num(num_d[g]), .den(ce4.tau), .quo(qd[g]));
  end

  // New distributions and output word.
  always_comb begin
    t_q   = '0;
    out_c = '0;
    for (int q = 0; q < DIRS; q++) begin
      t_q = s2[DIV_Q_W].neg_d[q] ? -signed'(WIDE_W'(qd[q])) : signed'(WIDE_W'(qd[q]));
      if (s2[DIV_Q_W].kind == KIND_SOLID) begin
        out_c[q*WORD_W +: WORD_W] = s2[DIV_Q_W].dists[q];
      end else begin
        out_c[q*WORD_W +: WORD_W] = sat_word(sx(s2[DIV_Q_W].dists[q]) + t_q);
      end
    end
    if (s2[DIV_Q_W].kind != KIND_SOLID) begin
      out_c[9*WORD_W +: WORD_W]  = s2[DIV_Q_W].rho;
      out_c[10*WORD_W +: WORD_W] = s2[DIV_Q_W].ux;
      out_c[11*WORD_W +: WORD_W] = s2[DIV_Q_W].uy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_Q_W; k++) begin
        v1[k] <= 1'b0;
        v2[k] <= 1'b0;
      end
      vv        <= 1'b0;
      ve1       <= 1'b0;
      ve2       <= 1'b0;
      ve3       <= 1'b0;
      ve4       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1[0] <= head_valid;
      for (int k = 1; k <= DIV_Q_W; k++) begin
        v1[k] <= v1[k-1];
        v2[k] <= v2[k-1];
      end
      vv        <= v1[DIV_Q_W];
      ve1       <= vv;
      ve2       <= ve1;
      ve3       <= ve2;
      ve4       <= ve3;
      v2[0]     <= ve4;
      out_valid <= v2[DIV_Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1[0]  <= s0_in;
      rr     <= rho_w * rho_w;
      wrp[0] <= signed'(WIDE_W'(cfg.w_rest)) * rho_w;
      wrp[1] <= signed'(WIDE_W'(cfg.w_axis)) * rho_w;
      wrp[2] <= signed'(WIDE_W'(cfg.w_diag)) * rho_w;
      s1[1]  <= s1_in;
      for (int k = 2; k <= DIV_Q_W; k++) begin
        s1[k] <= s1[k-1];
      end
      for (int k = 1; k <= DIV_Q_W; k++) begin
        s2[k] <= s2[k-1];
      end

      cv <= cv_in;

      ce1 <= cv;
      ce2 <= ce1;
      ce3 <= ce2;
      ce4 <= ce3;
      cu  <= cu_c;
      uxx <= sx(ce1.ux) * sx(ce1.ux);
      uyy <= sx(ce1.uy) * sx(ce1.uy);
      for (int q = 0; q < DIRS; q++) begin
        cup[q]  <= sx(cu_c[q]) * sx(cu_c[q]);
        feqp[q] <= sx(ce3.wr[wclass(q)]) * sx(polys[q]);
      end
      polys <= poly_c;

      s2[0] <= s2_in;

      out_data <= out_c;
    end
  end

endmodule

// ----- src/lattice_bgk_cell_collision_top.sv -----
// Top level of the D2Q9 BGK cell collision block: ports, configuration registers, parts.
`timescale 1ns / 1ps
// Throughput: one cell per cycle while the output is not stalled; the velocity and
// relaxation dividers in series, 35 register stages each, set most of the depth.
// A stalled output freezes the collision pipeline; a four-entry queue keeps input open.
// Reset clears all valid state and loads the default registers (full equilibrium,
// outflow 2.0, inflow 1.0, weights 4/9, 1/9, 1/36).
module lattice_bgk_cell_collision_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [287:0]                     s_tdata,   // dist_0 .. dist_8, 32 bits each
  input  logic [1:0]                       s_tuser,   // cell_kind
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [383:0]                     m_tdata,   // new_dist_0 .. new_dist_8, density,
                                                      // velocity_x, velocity_y, 32 bits each
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lbgk_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);
  import lbgk_pkg::*;

  cfg_t  cfg;
  logic  push;
  logic  full;
  logic  pop;
  logic  head_valid;
  cell_t push_item;
  cell_t head_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_eq     <= 1'b1;
      cfg.outflow_rho <= 31'd536870912;
      cfg.inflow_rho  <= 31'd268435456;
      cfg.w_rest      <= 29'd119304647;
      cfg.w_axis      <= 29'd29826162;
      cfg.w_diag      <= 29'd7456540;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FULL_EQ:     cfg.full_eq     <= cfg_data[0];
        REG_OUTFLOW_RHO: cfg.outflow_rho <= cfg_data[30:0];
        REG_INFLOW_RHO:  cfg.inflow_rho  <= cfg_data[30:0];
        REG_W_REST:      cfg.w_rest      <= cfg_data[28:0];
        REG_W_AXIS:      cfg.w_axis      <= cfg_data[28:0];
        REG_W_DIAG:      cfg.w_diag      <= cfg_data[28:0];
        default: begin
        end
      endcase
    end
  end

  lbgk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  lbgk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  lbgk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// ----- tb/sv/tb_lattice_bgk_cell_collision_checker.sv -----
// Checker that predicts each cell collision result and compares it with the block output.
`timescale 1ns / 1ps
module tb_lattice_bgk_cell_collision_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [287:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [383:0] m_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [lbgk_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending
);
  import lbgk_pkg::*;

  localparam logic signed [63:0] UNIT = 64'sd1 <<< 28;
  localparam logic signed [63:0] WMAX = 64'sd2147483647;
  localparam logic signed [63:0] WMIN = -64'sd2147483648;

  logic        m_full_eq;
  logic [30:0] m_out_rho;
  logic [30:0] m_in_rho;
  logic [28:0] m_w_rest;
  logic [28:0] m_w_axis;
  logic [28:0] m_w_diag;

  logic [383:0] expected_cells[$];
  int results_seen;

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> 28;
  endfunction

  function automatic logic signed [63:0] qdiv(input logic signed [63:0] n,
                                              input logic signed [63:0] d);
    logic signed [63:0] p;
    p = n * UNIT;
    return p / d;
  endfunction

  function automatic logic [383:0] collide(input logic [1:0] kind, input logic [287:0] data);
    logic signed [63:0] f[9];
    logic signed [63:0] rho, mx, my, ux, uy, tau, usq, w, wr, cu, cu2, poly, feq, nf;
    logic [383:0] r;
    int dx[9];
    int dy[9];
    dx = '{0, 1, -1, 0, 0, 1, -1, 1, -1};
    dy = '{0, 0, 0, 1, -1, 1, -1, -1, 1};
    r = '0;
    rho = 0;
    ux = 0;
    uy = 0;
    for (int q = 0; q < 9; q++) begin
      f[q] = 64'(signed'(data[q*32 +: 32]));
      rho += f[q];
    end
    if (kind == KIND_SOLID) begin
      r[287:0] = data;
      return r;
    end
    rho = clamp(rho);
    if (kind == KIND_OUTFLOW) rho = 64'(m_out_rho);
    if (kind == KIND_INFLOW) rho = 64'(m_in_rho);
    mx = f[1] - f[2] + f[5] - f[6] + f[7] - f[8];
    my = f[3] - f[4] + f[5] - f[6] + f[8] - f[7];
    if (rho != 0) begin
      ux = clamp(qdiv(mx, rho));
      uy = clamp(qdiv(my, rho));
    end
    tau = (UNIT + qmul(rho, rho)) >>> 1;
    usq = qmul(ux, ux) + qmul(uy, uy);
    for (int q = 0; q < 9; q++) begin
      if (q == 0) w = 64'(m_w_rest);
      else if (q <= 4) w = 64'(m_w_axis);
      else w = 64'(m_w_diag);
      wr = clamp(qmul(w, rho));
      if (m_full_eq) begin
        cu = clamp(dx[q] * ux + dy[q] * uy);
        cu2 = qmul(cu, cu);
        poly = UNIT + 3 * cu + ((9 * cu2) >>> 1) - ((3 * usq) >>> 1);
        feq = clamp(qmul(wr, clamp(poly)));
      end else begin
        feq = wr;
      end
      nf = clamp(f[q] + qdiv(feq - f[q], tau));
      r[q*32 +: 32] = nf[31:0];
    end
    r[288 +: 32] = rho[31:0];
    r[320 +: 32] = ux[31:0];
    r[352 +: 32] = uy[31:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count++;
    $display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  assign pending = expected_cells.size();

  always @(posedge clk) begin
    if (rst) begin
      m_full_eq <= 1'b1;
      m_out_rho <= 31'd536870912;
      m_in_rho <= 31'd268435456;
      m_w_rest <= 29'd119304647;
      m_w_axis <= 29'd29826162;
      m_w_diag <= 29'd7456540;
      results_seen = 0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FULL_EQ: m_full_eq <= cfg_data[0];
          REG_OUTFLOW_RHO: m_out_rho <= cfg_data[30:0];
          REG_INFLOW_RHO: m_in_rho <= cfg_data[30:0];
          REG_W_REST: m_w_rest <= cfg_data[28:0];
          REG_W_AXIS: m_w_axis <= cfg_data[28:0];
          REG_W_DIAG: m_w_diag <= cfg_data[28:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_cells.push_back(collide(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_cells.size() == 0) begin
          report("unexpected transfer", m_tdata[31:0], 32'd0);
        end else begin
          logic [383:0] want;
          string names[12];
          names = '{"new_dist_0", "new_dist_1", "new_dist_2", "new_dist_3", "new_dist_4",
                    "new_dist_5", "new_dist_6", "new_dist_7", "new_dist_8", "density",
                    "velocity_x", "velocity_y"};
          want = expected_cells.pop_front();
          for (int k = 0; k < 12; k++)
            if (m_tdata[k*32 +: 32] !== want[k*32 +: 32])
              report(names[k], m_tdata[k*32 +: 32], want[k*32 +: 32]);
        end
        results_seen++;
      end
    end
  end

endmodule

// ----- tb/sv/tb_lattice_bgk_cell_collision_top.sv -----
// Testbench top: drives cells and register writes into the collision block and gives the verdict.
`timescale 1ns / 1ps
module tb_lattice_bgk_cell_collision_top;
  import lbgk_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [287:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [383:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count;
  int pending;
  int cells_sent = 0;
  bit sink_stall_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lattice_bgk_cell_collision_top u_top (.*);

  tb_lattice_bgk_cell_collision_checker u_checker (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  always @(posedge clk) begin
    if (!sink_stall_on) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 99) < 70);
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic send_cell(input logic [1:0] kind, input logic [287:0] data, input bit gaps);
    int g;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    cells_sent++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_dist(input int style);
    case (style)
      0: return $urandom();
      1: return 32'(int'($urandom_range(0, 1 << 27)) - (1 << 25));
      default: return 32'($urandom_range(0, 1 << 26));
    endcase
  endfunction

  function automatic logic [287:0] make_cell(input int style);
    logic [287:0] d;
    for (int q = 0; q < 9; q++) d[q*32 +: 32] = rand_dist(style);
    return d;
  endfunction

  task automatic random_phase(input int count, input bit gaps);
    for (int i = 0; i < count; i++) begin
      send_cell(2'($urandom_range(0, 3)), make_cell($urandom_range(0, 4) == 0 ? 0 :
                $urandom_range(1, 2)), gaps);
      if (i == count / 2) begin
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_cell(KIND_FLUID, '0, 1'b0);
    send_cell(KIND_FLUID, {9{32'h7fffffff}}, 1'b0);
    send_cell(KIND_FLUID, {9{32'h80000000}}, 1'b0);
    send_cell(KIND_FLUID, {9{32'hffffffff}}, 1'b0);
    send_cell(KIND_SOLID, {9{32'h7fffffff}}, 1'b0);
    send_cell(KIND_SOLID, make_cell(0), 1'b0);
    send_cell(KIND_OUTFLOW, '0, 1'b0);
    send_cell(KIND_INFLOW, {9{32'h80000000}}, 1'b0);
    send_cell(KIND_FLUID, {32'h10000000, 32'hf0000000, 224'h0}, 1'b0);
    send_cell(KIND_FLUID, {256'h0, 32'h10000000}, 1'b0);
    send_cell(KIND_FLUID, {9{32'h01c71c71}}, 1'b0);
    send_cell(KIND_FLUID, {9{32'hfe38e38f}}, 1'b0);
    s_tvalid <= 1'b0;
    random_phase(150, 1'b1);
    drain();
    write_reg(REG_FULL_EQ, 32'h0);
    write_reg(REG_OUTFLOW_RHO, 32'h0);
    write_reg(REG_INFLOW_RHO, 32'hffffffff);
    write_reg(REG_W_REST, 32'h10000000);
    write_reg(REG_W_AXIS, 32'h0);
    write_reg(REG_W_DIAG, 32'hffffffff);
    send_cell(KIND_OUTFLOW, make_cell(1), 1'b0);
    send_cell(KIND_INFLOW, make_cell(1), 1'b0);
    random_phase(150, 1'b1);
    drain();
    write_reg(REG_FULL_EQ, 32'h1);
    write_reg(REG_OUTFLOW_RHO, 32'h7fffffff);
    write_reg(REG_INFLOW_RHO, 32'h00000001);
    write_reg(REG_W_REST, 32'h1fffffff);
    write_reg(REG_W_AXIS, 32'h10000000);
    write_reg(REG_W_DIAG, 32'h0);
    sink_stall_on = 1'b0;
    random_phase(150, 1'b0);
    sink_stall_on = 1'b1;
    drain();
    write_reg(REG_OUTFLOW_RHO, $urandom());
    write_reg(REG_INFLOW_RHO, $urandom());
    write_reg(REG_W_REST, 32'd119304647);
    write_reg(REG_W_AXIS, 32'd29826162);
    write_reg(REG_W_DIAG, 32'd7456540);
    random_phase(190, 1'b1);
    drain();
    $display("Sent %0d cells of all four kinds over four register settings,", cells_sent);
    $display("with both equilibrium modes and random gaps and stalls on both sides.");
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
